[rtl/hsq_pkg.sv]
// Shared types, codes and constants of the homing sequencer.
package hsq_pkg;

  // Internal width of the offset arithmetic; results are shown in 32 bits.
  localparam int unsigned PosWidth = 32;
  localparam logic [31:0] OffsetMask =
      (PosWidth >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << PosWidth) - 64'd1);

  localparam logic [3:0] ModeHoming = 4'd6;
  localparam logic [3:0] ModeCsp    = 4'd8;
  localparam logic [7:0] ShownHoming = 8'd6;
  localparam logic [7:0] ShownCsp    = 8'd8;

  localparam logic [2:0] OpTick    = 3'd0;
  localparam logic [2:0] OpStart   = 3'd1;
  localparam logic [2:0] OpCancel  = 3'd2;
  localparam logic [2:0] OpRelease = 3'd3;
  localparam logic [2:0] OpUnhome  = 3'd4;

  localparam logic [3:0] PhIdle      = 4'd0;
  localparam logic [3:0] PhSwitch    = 4'd1;
  localparam logic [3:0] PhWaitMode  = 4'd2;
  localparam logic [3:0] PhWaitAtt   = 4'd3;
  localparam logic [3:0] PhWaitCsp   = 4'd4;
  localparam logic [3:0] PhFinal     = 4'd5;
  localparam logic [3:0] PhFinalWait = 4'd6;
  localparam logic [3:0] PhDone      = 4'd7;
  localparam logic [3:0] PhError     = 4'd8;

  localparam logic [1:0] ActNone    = 2'd0;
  localparam logic [1:0] ActSync    = 2'd1;
  localparam logic [1:0] ActMove    = 2'd2;
  localparam logic [1:0] ActSetPlan = 2'd3;

  localparam logic [2:0] RegHomeOffset   = 3'd0;
  localparam logic [2:0] RegHomePosition = 3'd1;
  localparam logic [2:0] RegFinalVel     = 3'd2;
  localparam logic [2:0] RegRefuse       = 3'd3;
  localparam logic [2:0] RegSkipFinal    = 3'd4;
  localparam logic [2:0] RegSyncFinal    = 3'd5;
  localparam logic [2:0] RegModeTimeout  = 3'd6;

  localparam logic [15:0] ModeTimeoutReset = 16'd5000;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         drive_mode_shown;
    logic               home_reached;
    logic               homing_fault;
    logic signed [31:0] motor_position;
    logic signed [31:0] backlash_now;
    logic [30:0]        velocity_limit;
    logic               planner_busy;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         mode_command;
    logic               home_start_bit;
    logic               is_homing;
    logic               is_homed;
    logic [3:0]         phase_code;
    logic               still_busy;
    logic [1:0]         position_action;
    logic signed [31:0] motor_ofs_load;
    logic signed [31:0] position_value;
    logic [30:0]        move_speed;
    logic               planner_enable;
    logic               sync_waiting;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] home_ofs;
    logic signed [31:0] home_position;
    logic signed [31:0] final_velocity;
    logic               refuse_rehome;
    logic               skip_final_move;
    logic               sync_final_move;
    logic [15:0]        mode_timeout;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [16:0] wait_count;
    logic        homing;
    logic        homed;
    logic        release_flag;
    logic [3:0]  mode;
    logic        start_bit;
    logic        planner_en;
  } seq_state_t;

endpackage

[rtl/hsq_cfg.sv]
// Configuration register file of the homing sequencer.
module hsq_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [2:0]         wr_addr_i,
  input  logic [31:0]        wr_data_i,
  output hsq_pkg::cfg_t      cfg_o
);
  import hsq_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_addr_i)
        RegHomeOffset:   cfg_d.home_ofs        = wr_data_i;
        RegHomePosition: cfg_d.home_position   = wr_data_i;
        RegFinalVel:     cfg_d.final_velocity  = wr_data_i;
        RegRefuse:       cfg_d.refuse_rehome   = wr_data_i[0];
        RegSkipFinal:    cfg_d.skip_final_move = wr_data_i[0];
        RegSyncFinal:    cfg_d.sync_final_move = wr_data_i[0];
        RegModeTimeout:  cfg_d.mode_timeout    = wr_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{home_ofs: '0, home_position: '0, final_velocity: '0,
                 refuse_rehome: 1'b0, skip_final_move: 1'b0,
                 sync_final_move: 1'b0, mode_timeout: ModeTimeoutReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/hsq_step.sv]
// Next-state and result logic for one item of the homing sequencer.
module hsq_step (
  input  hsq_pkg::seq_state_t st_i,
  input  hsq_pkg::cfg_t       cfg_i,
  input  hsq_pkg::in_item_t   item_i,
  output hsq_pkg::seq_state_t st_o,
  output hsq_pkg::out_item_t  res_o
);
  import hsq_pkg::*;

  seq_state_t  nxt;
  logic        busy;
  logic [1:0]  action;
  logic [31:0] offset_val;
  logic [31:0] pos_val;
  logic [30:0] speed_val;
  logic [16:0] cnt_inc;
  logic        timed_out;
  logic [31:0] diff;
  logic        skip_move;
  logic        fv_pos;
  logic [30:0] speed_pick;

  assign cnt_inc   = st_i.wait_count + 17'd1;
  assign timed_out = cnt_inc > {1'b0, cfg_i.mode_timeout};
  assign diff      = item_i.motor_position - item_i.backlash_now - cfg_i.home_ofs;
  assign skip_move = cfg_i.skip_final_move || (cfg_i.home_position == cfg_i.home_ofs);
  assign fv_pos    = !cfg_i.final_velocity[31] && (cfg_i.final_velocity != '0);
  assign speed_pick = (fv_pos && (cfg_i.final_velocity[30:0] < item_i.velocity_limit))
                      ? cfg_i.final_velocity[30:0] : item_i.velocity_limit;

  always_comb begin
    nxt        = st_i;
    busy       = 1'b0;
    action     = ActNone;
    offset_val = '0;
    pos_val    = '0;
    speed_val  = '0;
    unique case (item_i.operation)
      OpTick: begin
        unique case (st_i.phase)
          PhSwitch: begin
            nxt.mode       = ModeHoming;
            nxt.start_bit  = 1'b0;
            nxt.wait_count = '0;
            nxt.phase      = PhWaitMode;
            busy           = 1'b1;
          end
          PhWaitMode: begin
            busy = 1'b1;
            if (item_i.drive_mode_shown == ShownHoming) begin
              nxt.start_bit  = 1'b1;
              nxt.wait_count = '0;
              nxt.phase      = PhWaitAtt;
            end else begin
              nxt.wait_count = cnt_inc;
              if (timed_out) nxt.phase = PhError;
            end
          end
          PhWaitAtt: begin
            busy = 1'b1;
            if (item_i.homing_fault) begin
              nxt.start_bit = 1'b0;
              nxt.phase     = PhError;
            end else if (item_i.home_reached) begin
              nxt.start_bit  = 1'b0;
              action         = ActSync;
              offset_val     = diff & OffsetMask;
              pos_val        = cfg_i.home_ofs;
              nxt.mode       = ModeCsp;
              nxt.wait_count = '0;
              nxt.phase      = PhWaitCsp;
            end
          end
          PhWaitCsp: begin
            busy = 1'b1;
            if (item_i.drive_mode_shown == ShownCsp) begin
              nxt.phase = PhFinal;
            end else begin
              nxt.wait_count = cnt_inc;
              if (timed_out) nxt.phase = PhError;
            end
          end
          PhFinal: begin
            busy = 1'b1;
            if (skip_move) begin
              nxt.phase = PhDone;
            end else if (!(cfg_i.sync_final_move && !st_i.release_flag)) begin
              nxt.release_flag = 1'b0;
              action           = ActMove;
              pos_val          = cfg_i.home_position;
              speed_val        = speed_pick;
              nxt.planner_en   = 1'b1;
              nxt.phase        = PhFinalWait;
            end
          end
          PhFinalWait: begin
            busy = 1'b1;
            if (!item_i.planner_busy) begin
              nxt.planner_en = 1'b0;
              nxt.phase      = PhDone;
            end
          end
          PhDone: begin
            nxt.homing = 1'b0;
            nxt.homed  = 1'b1;
            nxt.phase  = PhIdle;
            action     = ActSetPlan;
            pos_val    = cfg_i.skip_final_move ? cfg_i.home_ofs : cfg_i.home_position;
          end
          PhError: begin
            nxt.start_bit = 1'b0;
            nxt.mode      = ModeCsp;
            nxt.homing    = 1'b0;
            nxt.homed     = 1'b0;
            nxt.phase     = PhIdle;
          end
          default: ;
        endcase
      end
      OpStart: begin
        if (!(cfg_i.refuse_rehome && st_i.homed)) begin
          nxt.homing       = 1'b1;
          nxt.homed        = 1'b0;
          nxt.release_flag = 1'b0;
          nxt.phase        = PhSwitch;
        end
      end
      OpCancel: begin
        if (st_i.homing || (st_i.phase != PhIdle)) nxt.phase = PhError;
      end
      OpRelease: nxt.release_flag = 1'b1;
      OpUnhome: begin
        if (!st_i.homing) nxt.homed = 1'b0;
      end
      default: ;
    endcase
  end

  assign st_o = nxt;

  assign res_o = '{mode_command:     nxt.mode,
                   home_start_bit:   nxt.start_bit,
                   is_homing:        nxt.homing,
                   is_homed:         nxt.homed,
                   phase_code:       nxt.phase,
                   still_busy:       busy,
                   position_action:  action,
                   motor_ofs_load:   offset_val,
                   position_value:   pos_val,
                   move_speed:       speed_val,
                   planner_enable:   nxt.planner_en,
                   sync_waiting:     (nxt.phase == PhFinal) && cfg_i.sync_final_move &&
                                     !nxt.release_flag};

endmodule

[rtl/cia402_drive_homing_sequencer.sv]
// Top level of the per-joint drive homing sequencer.
// Flow: the accepting edge loads the input register, and the result register is loaded
// from it when it has room; a stalled result holds the result register.
// Throughput: one item per cycle while the result is not stalled; the step logic
// between the two registers is combinational and handles a whole item.
// Reset: asynchronous, active low; phase idle, CSP mode commanded, flags clear,
// both pipeline stages empty, registers at their defaults (mode timeout 5000).
module cia402_drive_homing_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hsq_pkg::in_item_t   in_item_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hsq_pkg::out_item_t  out_item_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_addr_i,
  input  logic [31:0]         cfg_data_i
);
  import hsq_pkg::*;

  cfg_t       cfg;
  seq_state_t st_q, st_next;
  out_item_t  res_d, res_q;
  in_item_t   s1_item_q;
  logic       s1_valid_q, s1_valid_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       s1_adv;
  logic       in_take;

  // Register writes are taken at once; software only writes while idle (a user rule, not enforced by the block).
  assign cfg_ready_o = 1'b1;

  hsq_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // The result register is free when empty or when its item leaves this edge.
  assign out_free   = !out_valid_q || !out_stall_i;
  // Advance the held item into the result register whenever there is room.
  assign s1_adv     = s1_valid_q && out_free;
  // Stall input only when the input register is full and cannot drain.
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  // Work out the item held in the input register against the current state.
  hsq_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg),
    .item_i (s1_item_q),
    .st_o   (st_next),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{phase: PhIdle, wait_count: '0, homing: 1'b0, homed: 1'b0,
                       release_flag: 1'b0, mode: ModeCsp, start_bit: 1'b0,
                       planner_en: 1'b0};
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      // Commit the sequencer state only when the item moves on.
      if (s1_adv) st_q <= st_next;
    end
  end

  // Payload registers: hold unless loaded.
  always_ff @(posedge clk_i) begin
    if (in_take) s1_item_q <= in_item_i;
    if (s1_adv)  res_q     <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

endmodule

[rtl/hsq_chk.sv]
// Port-level checker for the homing sequencer, bound to the top level.
module hsq_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input hsq_pkg::out_item_t out_item_o
);
  import hsq_pkg::*;

  // A busy tick only happens inside a homing sequence.
  a_busy_homing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.still_busy |-> out_item_o.is_homing)
    else $error("still_busy without is_homing");

  // Homing in progress and homed never show together.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.is_homing && out_item_o.is_homed))
    else $error("is_homing and is_homed both set");

  // Only homing or CSP mode is ever commanded.
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.mode_command == ModeHoming) ||
                    (out_item_o.mode_command == ModeCsp))
    else $error("illegal mode command");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind cia402_drive_homing_sequencer hsq_chk u_hsq_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
